FILE: design/hppc_pkg.sv
package hppc_pkg;

    localparam int MAX_PULSES_DEF  = 5;
    localparam int MAX_SAMPLES_DEF = 4096;
    localparam int SAMPLE_BITS_DEF = 16;

    // sample index wraps at 4096 whatever the record length
    localparam int INDEX_BITS = 12;

    localparam int UPPER_RESET = 262;
    localparam int LOWER_RESET = 147;

    // register indexes on the configuration port
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UPPER = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOWER = 1'b1;

endpackage

FILE: design/hppc_trigger.sv
module hppc_trigger #(
    parameter int MAX_PULSES  = hppc_pkg::MAX_PULSES_DEF,
    parameter int MAX_SAMPLES = hppc_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = hppc_pkg::SAMPLE_BITS_DEF,
    localparam int CW = $clog2(MAX_SAMPLES + 1),
    localparam int KW = (MAX_PULSES > 1) ? $clog2(MAX_PULSES) : 1,
    localparam int NW = $clog2(MAX_PULSES + 1),
    localparam int IW = hppc_pkg::INDEX_BITS
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       cfg_we,
    input  logic [hppc_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
    input  logic [SAMPLE_BITS-1:0]                     cfg_wdata,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic [SAMPLE_BITS-1:0]                     in_sample,
    input  logic                                       in_last,
    input  logic                                       busy,
    output logic                                       snap_load,
    output logic [CW-1:0]                              snap_total,
    output logic                                       snap_ovf,
    output logic [NW-1:0]                              snap_count,
    output logic [IW-1:0]                              snap_pos [MAX_PULSES],
    output logic [MAX_PULSES-1:0]                      snap_wr
);

    logic signed [SAMPLE_BITS-1:0] upper_reg, lower_reg;

    logic                          in_valid_reg, in_valid_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          last_reg;

    logic                          high_reg, high_next;
    logic [CW-1:0]                 total_reg, total_next;
    logic [IW-1:0]                 idx_reg;
    logic signed [SAMPLE_BITS-1:0] peak_reg, peak_next, peak_base;
    logic                          ovf_reg, ovf_next;
    logic [IW-1:0]                 pos_reg [MAX_PULSES];
    logic [IW-1:0]                 pos_next [MAX_PULSES];
    logic [MAX_PULSES-1:0]         wr_reg, wr_next;

    logic          advance, rise, fall, upd, slot_ok;
    logic [KW-1:0] slot;

    assign advance  = in_valid_reg && !(last_reg && busy);
    assign in_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    assign rise = !high_reg && (sample_reg >= upper_reg);
    assign fall = high_reg && (sample_reg < lower_reg);

    always_comb begin
        high_next  = high_reg;
        total_next = total_reg;
        ovf_next   = ovf_reg;
        peak_base  = peak_reg;
        if (rise) begin
            high_next = 1'b1;
            if (int'(total_reg) >= MAX_PULSES) begin
                ovf_next = 1'b1;
            end
            if (int'(total_reg) < MAX_SAMPLES) begin
                total_next = total_reg + CW'(1);
            end
        end else if (fall) begin
            high_next = 1'b0;
            peak_base = '0;
        end
    end

    assign upd     = high_next && (peak_base < sample_reg);
    assign slot_ok = (total_next != '0) && (int'(total_next) <= MAX_PULSES);
    assign slot    = KW'(total_next - CW'(1));

    always_comb begin
        peak_next = upd ? sample_reg : peak_base;
        wr_next   = wr_reg;
        for (int i = 0; i < MAX_PULSES; i++) begin
            pos_next[i] = pos_reg[i];
        end
        if (upd && slot_ok) begin
            pos_next[slot] = idx_reg;
            wr_next[slot]  = 1'b1;
        end
    end

    assign snap_load  = advance && last_reg;
    assign snap_total = total_next;
    assign snap_ovf   = ovf_next;
    assign snap_pos   = pos_next;
    assign snap_wr    = wr_next;

    always_comb begin
        if (int'(total_next) < MAX_PULSES) begin
            snap_count = (total_next == '0) ? NW'(1) : NW'(total_next);
        end else begin
            snap_count = NW'(MAX_PULSES);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_reg    <= SAMPLE_BITS'(hppc_pkg::UPPER_RESET);
            lower_reg    <= SAMPLE_BITS'(hppc_pkg::LOWER_RESET);
            in_valid_reg <= 1'b0;
            high_reg     <= 1'b0;
            total_reg    <= '0;
            idx_reg      <= '0;
            peak_reg     <= '0;
            ovf_reg      <= 1'b0;
            wr_reg       <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    hppc_pkg::CFG_UPPER: upper_reg <= cfg_wdata;
                    hppc_pkg::CFG_LOWER: lower_reg <= cfg_wdata;
                endcase
            end
            in_valid_reg <= in_valid_next;
            if (advance) begin
                if (last_reg) begin
                    high_reg  <= 1'b0;
                    total_reg <= '0;
                    idx_reg   <= '0;
                    peak_reg  <= '0;
                    ovf_reg   <= 1'b0;
                    wr_reg    <= '0;
                end else begin
                    high_reg  <= high_next;
                    total_reg <= total_next;
                    idx_reg   <= idx_reg + IW'(1);
                    peak_reg  <= peak_next;
                    ovf_reg   <= ovf_next;
                    wr_reg    <= wr_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            sample_reg <= in_sample;
            last_reg   <= in_last;
        end
        if (advance) begin
            pos_reg <= pos_next;
        end
    end

endmodule

FILE: design/hppc_emitter.sv
module hppc_emitter #(
    parameter int MAX_PULSES  = hppc_pkg::MAX_PULSES_DEF,
    parameter int MAX_SAMPLES = hppc_pkg::MAX_SAMPLES_DEF,
    localparam int CW = $clog2(MAX_SAMPLES + 1),
    localparam int KW = (MAX_PULSES > 1) ? $clog2(MAX_PULSES) : 1,
    localparam int NW = $clog2(MAX_PULSES + 1),
    localparam int IW = hppc_pkg::INDEX_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  snap_load,
    input  logic [CW-1:0]         snap_total,
    input  logic                  snap_ovf,
    input  logic [NW-1:0]         snap_count,
    input  logic [IW-1:0]         snap_pos [MAX_PULSES],
    input  logic [MAX_PULSES-1:0] snap_wr,
    output logic                  busy,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [CW-1:0]         out_count,
    output logic [KW-1:0]         out_number,
    output logic [IW-1:0]         out_position,
    output logic                  out_pos_valid,
    output logic                  out_overflow,
    output logic                  out_last
);

    logic                  active_reg;
    logic [KW-1:0]         k_reg;
    logic [NW-1:0]         n_reg;
    logic [CW-1:0]         total_reg;
    logic                  ovf_reg;
    logic [IW-1:0]         pos_reg [MAX_PULSES];
    logic [MAX_PULSES-1:0] wr_reg;

    logic          valid_reg, valid_next;
    logic [CW-1:0] count_reg;
    logic [KW-1:0] number_reg;
    logic [IW-1:0] position_reg;
    logic          pos_valid_reg, overflow_reg, last_reg;

    logic load_out, final_one;

    assign busy      = active_reg;
    assign load_out  = active_reg && (!valid_reg || out_ready);
    assign final_one = (NW'(k_reg) == n_reg - NW'(1));

    always_comb begin
        valid_next = valid_reg;
        if (load_out) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            k_reg      <= '0;
            valid_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (snap_load) begin
                active_reg <= 1'b1;
                k_reg      <= '0;
            end else if (load_out) begin
                if (final_one) begin
                    active_reg <= 1'b0;
                    k_reg      <= '0;
                end else begin
                    k_reg <= k_reg + KW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_load) begin
            n_reg     <= snap_count;
            total_reg <= snap_total;
            ovf_reg   <= snap_ovf;
            pos_reg   <= snap_pos;
            wr_reg    <= snap_wr;
        end
        if (load_out) begin
            count_reg     <= total_reg;
            number_reg    <= k_reg;
            position_reg  <= wr_reg[k_reg] ? pos_reg[k_reg] : '0;
            pos_valid_reg <= wr_reg[k_reg];
            overflow_reg  <= ovf_reg;
            last_reg      <= final_one;
        end
    end

    assign out_valid     = valid_reg;
    assign out_count     = count_reg;
    assign out_number    = number_reg;
    assign out_position  = position_reg;
    assign out_pos_valid = pos_valid_reg;
    assign out_overflow  = overflow_reg;
    assign out_last      = last_reg;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        snap_load |-> !active_reg)
        else $error("record loaded while previous one still draining");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (NW'(k_reg) < n_reg))
        else $error("result index beyond record size");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (n_reg != '0))
        else $error("active record with no results");

    a_drain_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && final_one) |=> !active_reg && valid_reg && last_reg)
        else $error("record did not close after final result");

endmodule

FILE: design/hysteresis_pulse_peak_counter.sv
// Hysteresis pulse counter with per-pulse peak position.
// Input stream s_*: one signed Q8.8 sample per transaction in s_tdata, s_tlast
// marks the final sample of a record. Output stream m_*: on a record end, one
// transaction per stored pulse (up to MAX_PULSES), or a single empty one when no
// pulse was stored; m_tlast marks the final result of the record.
// Thresholds are written through cfg_we/cfg_index/cfg_wdata; the user must do
// so only while idle, which is not enforced. Throughput: one sample per cycle
// unless stalled. The trigger stage registers each sample and updates the
// record state from it in the next cycle. A record end is snapshotted into
// the result sequencer, which then issues one result per cycle while m_tready
// allows; results leave through the snapshot and output registers. Samples of
// the next record keep flowing during that drain; only a second record end
// waits until the previous record's results have all been handed to the
// output register. Receiver stall: the output register holds its transaction,
// the sequencer waits, and the input side backs up once a pending record end
// meets it. Reset (aresetn low, synchronous): thresholds return to 262 and
// 147, the record state is cleared and both channels go empty.
module hysteresis_pulse_peak_counter #(
    parameter int MAX_PULSES  = hppc_pkg::MAX_PULSES_DEF,
    parameter int MAX_SAMPLES = hppc_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = hppc_pkg::SAMPLE_BITS_DEF,
    localparam int CW       = $clog2(MAX_SAMPLES + 1),
    localparam int KW       = (MAX_PULSES > 1) ? $clog2(MAX_PULSES) : 1,
    localparam int NW       = $clog2(MAX_PULSES + 1),
    localparam int IW       = hppc_pkg::INDEX_BITS,
    localparam int IN_W     = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_BITS = CW + KW + IW,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [hppc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [SAMPLE_BITS-1:0]              cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [IN_W-1:0]                     s_tdata,   // sample
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [OUT_W-1:0]                    m_tdata,   // pulse_count, pulse_number, peak_position
    output logic [1:0]                          m_tuser,   // position_valid, overflow
    output logic                                m_tlast
);

    logic                  busy, snap_load, snap_ovf;
    logic [CW-1:0]         snap_total;
    logic [NW-1:0]         snap_count;
    logic [IW-1:0]         snap_pos [MAX_PULSES];
    logic [MAX_PULSES-1:0] snap_wr;

    logic [CW-1:0] out_count;
    logic [KW-1:0] out_number;
    logic [IW-1:0] out_position;
    logic          out_pos_valid, out_overflow;

    hppc_trigger #(
        .MAX_PULSES  (MAX_PULSES),
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_trigger (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_sample  (s_tdata[SAMPLE_BITS-1:0]),
        .in_last    (s_tlast),
        .busy       (busy),
        .snap_load  (snap_load),
        .snap_total (snap_total),
        .snap_ovf   (snap_ovf),
        .snap_count (snap_count),
        .snap_pos   (snap_pos),
        .snap_wr    (snap_wr)
    );

    hppc_emitter #(
        .MAX_PULSES  (MAX_PULSES),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_emitter (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .snap_load     (snap_load),
        .snap_total    (snap_total),
        .snap_ovf      (snap_ovf),
        .snap_count    (snap_count),
        .snap_pos      (snap_pos),
        .snap_wr       (snap_wr),
        .busy          (busy),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_count     (out_count),
        .out_number    (out_number),
        .out_position  (out_position),
        .out_pos_valid (out_pos_valid),
        .out_overflow  (out_overflow),
        .out_last      (m_tlast)
    );

    assign m_tdata = OUT_W'({out_position, out_number, out_count});
    assign m_tuser = {out_overflow, out_pos_valid};

endmodule
